@@ hdl/tma_pkg.sv @@
package tma_pkg;

  localparam int WINDOW_LEN = 20;
  localparam int IDX_W      = 5;
  localparam int SAMPLE_W   = 8;
  localparam int SUM_W      = 13;
  localparam int TENTHS_W   = 12;
  localparam int READING_W  = 12;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0]  MAX_SUM  = SUM_W'(WINDOW_LEN * 255);

  // floor(9 * t / 50) == floor(t * F_MULT / 2**F_SHIFT) for t up to 2550
  localparam int F_SHIFT = 20;
  localparam int F_MUL_W = 18;
  localparam logic [F_MUL_W-1:0] F_MULT = F_MUL_W'(((1 << F_SHIFT) + 49) / 50 * 9);
  localparam int PROD_W  = TENTHS_W + F_MUL_W;
  localparam int FDEG_W  = PROD_W - F_SHIFT;
  localparam logic [READING_W-1:0] F_OFFSET = READING_W'(32);

  localparam logic [ADDR_W-3:0] REG_FAHRENHEIT_MODE = '0;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [SAMPLE_W-1:0] data;
  } ring_wr_t;

endpackage

@@ hdl/temperature_moving_average_unit.sv @@
// temperature moving average over the last 20 samples
// input channel: in_valid / in_stall with temp_sample, one word per sample
// output channel: out_valid / out_stall with reading, one word per sample
// a word moves at a clock edge where valid is high and stall is low
// reading is the window average in tenths of a degree celsius, or whole
// degrees fahrenheit when fahrenheit_mode (apb address 0, bit 0) is set
// throughput: one sample per cycle while the output is not stalled, set
// by the ring read in the first stage and the read-modify-write of the
// running sum in the second
// a stalled output holds its word and the pipeline behind it; in_stall
// is high exactly while the output word is held
// reset clears the window sum, ring fill bits, write slot, pipeline and
// mode; unfilled ring slots count as zero samples; the user must write
// configuration only while no sample is in flight, unchecked by the block
module temperature_moving_average_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tma_pkg::ADDR_W-1:0]    paddr,
  input  logic [tma_pkg::DATA_W-1:0]    pwdata,
  output logic [tma_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tma_pkg::SAMPLE_W-1:0]  temp_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tma_pkg::READING_W-1:0] reading
);
  import tma_pkg::*;

  logic                 fahrenheit_mode;
  logic                 advance;
  logic                 rd_en;
  logic [IDX_W-1:0]     write_index;
  logic [IDX_W-1:0]     write_index_next;
  logic                 s1_valid;
  logic [IDX_W-1:0]     s1_idx;
  logic [SAMPLE_W-1:0]  s1_sample;
  logic [SAMPLE_W-1:0]  old_sample;
  logic [SUM_W-1:0]     window_sum;
  logic [SUM_W-1:0]     window_sum_next;
  logic                 s2_valid;
  logic [SUM_W-1:0]     s2_sum;
  logic [TENTHS_W-1:0]  tenths;
  logic [PROD_W-1:0]    f_prod;
  logic [READING_W-1:0] reading_next;
  ring_wr_t             ring_wr;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_FAHRENHEIT_MODE)
                  ? {{(DATA_W-1){1'b0}}, fahrenheit_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fahrenheit_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[ADDR_W-1:2] == REG_FAHRENHEIT_MODE) begin
      fahrenheit_mode <= pwdata[0];
    end
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign rd_en    = advance && in_valid;

  assign write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;

  tma_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (write_index),
    .rd_data (old_sample),
    .wr      (ring_wr)
  );

  // stage 1: ring read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      s1_valid    <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      if (in_valid) begin
        write_index <= write_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_idx    <= write_index;
      s1_sample <= temp_sample;
    end
  end

  // stage 2: running sum update and ring write back
  assign window_sum_next = window_sum - SUM_W'(old_sample) + SUM_W'(s1_sample);

  always_comb begin
    ring_wr.en   = advance && s1_valid;
    ring_wr.addr = s1_idx;
    ring_wr.data = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      s2_valid   <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        window_sum <= window_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_sum <= window_sum_next;
    end
  end

  // stage 3: unit conversion into the output register
  assign tenths = s2_sum[SUM_W-1:1];
  assign f_prod = PROD_W'(tenths) * PROD_W'(F_MULT);

  always_comb begin
    if (fahrenheit_mode) begin
      reading_next = READING_W'(f_prod[PROD_W-1:F_SHIFT]) + F_OFFSET;
    end else begin
      reading_next = READING_W'(tenths);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      reading <= reading_next;
    end
  end

`ifndef SYNTHESIS
  a_index_in_ring: assert property (@(posedge clk) disable iff (rst)
    write_index <= LAST_IDX)
    else $error("write slot outside ring");

  a_sum_bounded: assert property (@(posedge clk) disable iff (rst)
    window_sum <= MAX_SUM)
    else $error("window sum above full-scale window");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (ring_wr.en && rd_en) |-> (ring_wr.addr != write_index))
    else $error("ring read and write hit the same slot");

  a_sum_tracks: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid) |=> (window_sum == s2_sum))
    else $error("window sum and stage sum disagree");
`endif

endmodule

@@ hdl/tma_ring.sv @@
module tma_ring (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [tma_pkg::IDX_W-1:0]    rd_addr,
  output logic [tma_pkg::SAMPLE_W-1:0] rd_data,
  input  tma_pkg::ring_wr_t            wr
);
  import tma_pkg::*;

  logic [SAMPLE_W-1:0] mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] filled;
  logic [SAMPLE_W-1:0] rd_word;
  logic                rd_filled;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // never-written slots read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (wr.en) begin
        filled[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_filled <= filled[rd_addr];
      end
    end
  end

  assign rd_data = rd_filled ? rd_word : '0;

endmodule

@@ tb/sv/temperature_moving_average_unit_tb.sv @@
`timescale 1ns / 1ps

class reading_scoreboard;
  logic [tma_pkg::SAMPLE_W-1:0]  ring [tma_pkg::WINDOW_LEN];
  logic [tma_pkg::IDX_W-1:0]     wr_slot;
  logic [tma_pkg::SUM_W-1:0]     win_sum;
  logic                          fahr_mode;
  logic [tma_pkg::READING_W-1:0] pending_readings [$];
  int                            errors;

  function new();
    foreach (ring[i]) ring[i] = '0;
    wr_slot   = '0;
    win_sum   = '0;
    fahr_mode = 1'b0;
    errors    = 0;
  endfunction

  function void write_reg(logic [tma_pkg::ADDR_W-1:0] addr, logic [tma_pkg::DATA_W-1:0] data);
    if ((addr >> 2) == 0) fahr_mode = data[0];
  endfunction

  function void note_sample(logic [tma_pkg::SAMPLE_W-1:0] s);
    logic [tma_pkg::IDX_W-1:0] slot;
    int tenths;
    int value;
    slot = (wr_slot >= tma_pkg::WINDOW_LEN) ? '0 : wr_slot;
    win_sum = win_sum - tma_pkg::SUM_W'(ring[slot]) + tma_pkg::SUM_W'(s);
    ring[slot] = s;
    slot = slot + 1'b1;
    if (slot >= tma_pkg::WINDOW_LEN) slot = '0;
    wr_slot = slot;
    tenths = int'(win_sum >> 1);
    if (fahr_mode) value = ((tenths * 9) / 5) / 10 + 32;
    else value = tenths;
    pending_readings.push_back(tma_pkg::READING_W'(value));
  endfunction

  function void check_reading(logic [tma_pkg::READING_W-1:0] actual);
    logic [tma_pkg::READING_W-1:0] want;
    if (pending_readings.size() == 0) begin
      $error("reading: expected none, actual %0d", actual);
      errors++;
    end else begin
      want = pending_readings.pop_front();
      if (actual !== want) begin
        $error("reading: expected %0d, actual %0d", want, actual);
        errors++;
      end
    end
  endfunction
endclass

module temperature_moving_average_unit_tb;
  import tma_pkg::*;

  localparam logic [ADDR_W-1:0] MODE_ADDR  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  temp_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [READING_W-1:0] reading;

  reading_scoreboard sb;
  bit tx_idle_on;
  bit rx_idle_on;
  int idle_cycles;

  temperature_moving_average_unit DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .temp_sample(temp_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .reading(reading)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // word monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(temp_sample);
      if (out_valid && !out_stall) sb.check_reading(reading);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stalls
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!rx_idle_on) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        hold = pick_gap();
      end
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    in_valid    <= 1'b1;
    temp_sample <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int run_left;
    int run_kind;
    int run_value;
    int pause_at;
    logic [SAMPLE_W-1:0] s;
    sb          = new();
    clk         = 1'b0;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    temp_sample = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // start-up ramp, full window of maximum samples, index wrap
    apb_write(MODE_ADDR, '0);
    send_sample(8'd0);
    repeat (20) send_sample(8'hFF);
    drain();
    // write to an unused register is ignored, only bit 0 of the mode counts
    apb_write(SPARE_ADDR, 32'hFFFF_FFFE);
    apb_write(MODE_ADDR, 32'h0000_0003);
    send_sample(8'hFF);
    send_sample(8'd0);
    send_sample(8'd128);
    drain();
    apb_write(MODE_ADDR, 32'hFFFF_FFFE);

    run_left = 0;
    run_kind = 0;
    run_value = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2) && (ph != 5);
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 40);
          run_kind  = $urandom_range(0, 4);
          run_value = ($urandom_range(0, 1) == 0) ? 0 : 255;
          if ($urandom_range(0, 2) == 0) run_value = $urandom_range(0, 255);
        end
        run_left--;
        case (run_kind)
          0: s = SAMPLE_W'($urandom_range(0, 255));
          1: s = SAMPLE_W'(run_value);
          2: s = SAMPLE_W'($urandom_range(0, 15));
          3: s = SAMPLE_W'($urandom_range(240, 255));
          default: s = SAMPLE_W'($urandom);
        endcase
        send_sample(s);
        if (n == pause_at) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending_readings.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      drain();
      apb_write(SPARE_ADDR, DATA_W'($urandom));
      apb_write(MODE_ADDR, {(DATA_W-1)'($urandom), ph[0] ^ 1'b1});
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/tma_pkg.sv
hdl/tma_ring.sv
hdl/temperature_moving_average_unit.sv
tb/sv/temperature_moving_average_unit_tb.sv
